/* design/sqfd_pkg.sv */
`timescale 1ns / 1ps
package sqfd_pkg;
	localparam int QueueDepth = 4;
	localparam int TimeBits = 16;
	localparam int IdxBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int FillBits = $clog2(QueueDepth + 1);

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] OC_DONE = 2'd0;
	localparam logic [1:0] OC_ABORT = 2'd1;
	localparam logic [1:0] OC_REJECT = 2'd2;

	typedef struct packed {
		logic [15:0] id;
		logic [TimeBits-1:0] arrival;
		logic [15:0] run;
		logic [15:0] dl;
	} job_t;

	// controller -> datapath
	typedef struct packed {
		logic arrive;     // store job into chosen queue
		logic tick;       // advance time and elapsed counts
		logic sel;        // server under drain
		logic pop;        // retire head of sel, load result register
		logic reject;     // load reject result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full_both;
		logic head_fires;  // head of sel retires on this tick
	} dp_sts_t;
endpackage

/* design/dual_queue_sqf_job_dispatcher_core.sv */
`timescale 1ns / 1ps
// channel | handshake        | payload
// in      | in_valid/ready   | operation job_id run_length deadline
// out     | out_valid/ready  | job_ref server outcome event_time wait_res last
// Arrival is accepted in idle; a rejection is shown as a result first. A tick scans
// server 1 then server 2, retiring jobs one at a time (one shared head compare, one result register).
// Up to 8 retirements per tick. Reset clears time,
// counts and fill levels; job storage has no reset. Output stalls hold drain.
module dual_queue_sqf_job_dispatcher_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	input  logic [15:0] job_id,
	input  logic [15:0] run_length,
	input  logic [15:0] deadline,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] job_ref,
	output logic [1:0] server,
	output logic [1:0] outcome,
	output logic [15:0] event_time,
	output logic [15:0] wait_res,
	output logic last
);
	import sqfd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic r_valid, r_ready, r_last, c_ready;
	logic [15:0] r_id, r_time, r_wait;
	logic [1:0] r_srv, r_oc;
	logic drain_end;
	logic busy_q;
	logic drain_pend;
	logic ob_held_more;
	logic [51:0] ob_out;

	// drain finishes when the controller returns to idle after being busy (tick or rejection)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else busy_q <= !c_ready;
	end
	assign drain_end = busy_q && c_ready;
	assign in_ready = c_ready && !drain_pend;

	// outbuf may still hold a "more" result at idle: finish it before new input
	assign drain_pend = ob_held_more;

	sqfd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(in_valid && !drain_pend), .in_ready(c_ready),
		.operation, .out_valid(r_valid), .out_ready(r_ready), .out_last(r_last),
		.cmd, .sts
	);

	sqfd_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .job_id, .run_length, .deadline,
		.res_id(r_id), .res_server(r_srv), .res_outcome(r_oc),
		.res_time(r_time), .res_wait(r_wait)
	);

	sqfd_outbuf u_ob (
		.clk, .arst_n, .up_valid(r_valid), .up_ready(r_ready), .up_more(!r_last),
		.drain_end(drain_end || (c_ready && !busy_q)),
		.up_data({r_id, r_srv, r_oc, r_time, r_wait}),
		.dn_valid(out_valid), .dn_ready(out_ready), .dn_last(last), .dn_data(ob_out)
	);
	assign {job_ref, server, outcome, event_time, wait_res} = ob_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ob_held_more <= 1'b0;
		else if (r_valid && r_ready) ob_held_more <= !r_last;
		else if (out_valid && out_ready) ob_held_more <= 1'b0;
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_TICK) |=> !in_ready)
		else $error("accept while busy");
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && outcome == OC_REJECT) |-> (last && server == 2'd0))
		else $error("reject not final");
	a_pop_fires: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> sts.head_fires) else $error("pop without retire");
`endif
endmodule

/* design/sqfd_datapath.sv */
`timescale 1ns / 1ps
module sqfd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  sqfd_pkg::dp_cmd_t cmd,
	output sqfd_pkg::dp_sts_t sts,
	input  logic [15:0] job_id,
	input  logic [15:0] run_length,
	input  logic [15:0] deadline,
	output logic [15:0] res_id,
	output logic [1:0] res_server,
	output logic [1:0] res_outcome,
	output logic [15:0] res_time,
	output logic [15:0] res_wait
);
	import sqfd_pkg::*;

	localparam logic [TimeBits-1:0] TimeMax = '1;

	logic [TimeBits-1:0] now_q;
	logic [15:0] elapsed_q [2];
	logic [FillBits-1:0] fill_q [2];
	job_t store_q [2][QueueDepth];

	logic tgt;
	job_t head;
	logic [15:0] el;
	logic [TimeBits-1:0] run_ext;
	logic done_ok, abort_ok;
	logic [TimeBits+1:0] d_done, d_abort, d_sel;

	always_comb begin
		if (fill_q[0] == '0) tgt = 1'b0;
		else if (fill_q[1] == '0) tgt = 1'b1;
		else tgt = (fill_q[0] <= fill_q[1]) ? 1'b0 : 1'b1;
	end

	assign head = store_q[cmd.sel][0];
	assign el = elapsed_q[cmd.sel];
	assign run_ext = TimeBits'(head.run);
	assign done_ok = (el == head.run) && ({2'b0, now_q} <= {2'b0, TimeBits'(head.dl)});
	assign abort_ok = ({16'b0, now_q} >= {{TimeBits{1'b0}}, head.dl});
	assign d_done = {2'b0, now_q} - {2'b0, head.arrival} - {2'b0, run_ext};
	assign d_abort = {2'b0, now_q} - {2'b0, head.arrival};
	assign d_sel = done_ok ? d_done : d_abort;

	assign sts.full_both = (fill_q[0] >= FillBits'(QueueDepth))
		&& (fill_q[1] >= FillBits'(QueueDepth));
	assign sts.head_fires = (fill_q[cmd.sel] != '0) && (done_ok || abort_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			elapsed_q[0] <= '0;
			elapsed_q[1] <= '0;
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else begin
			if (cmd.arrive && !sts.full_both) begin
				if (fill_q[tgt] == '0) elapsed_q[tgt] <= '0;
				fill_q[tgt] <= fill_q[tgt] + 1'b1;
			end
			if (cmd.tick) begin
				if (now_q != TimeMax) now_q <= now_q + 1'b1;
				for (int s = 0; s < 2; s++)
					if (elapsed_q[s] != 16'hFFFF) elapsed_q[s] <= elapsed_q[s] + 1'b1;
			end
			if (cmd.pop) begin
				fill_q[cmd.sel] <= fill_q[cmd.sel] - 1'b1;
				elapsed_q[cmd.sel] <= '0;
			end
		end
	end

	// job storage: shifts on pop, written at fill on arrival
	always_ff @(posedge clk) begin
		if (cmd.arrive && !sts.full_both)
			store_q[tgt][fill_q[tgt][IdxBits-1:0]] <= '{id: job_id, arrival: now_q,
				run: run_length, dl: deadline};
		if (cmd.pop)
			for (int i = 1; i < QueueDepth; i++)
				store_q[cmd.sel][i-1] <= store_q[cmd.sel][i];
	end

	// result register; delay clamped to 0..65535
	always_ff @(posedge clk) begin
		if (cmd.reject) begin
			res_id <= job_id;
			res_server <= 2'd0;
			res_outcome <= OC_REJECT;
			res_time <= 16'(now_q);
			res_wait <= '0;
		end else if (cmd.pop) begin
			res_id <= head.id;
			res_server <= {1'b0, cmd.sel} + 2'd1;
			res_outcome <= done_ok ? OC_DONE : OC_ABORT;
			res_time <= 16'(now_q);
			if (d_sel[TimeBits+1]) res_wait <= '0;
			else if (d_sel > (TimeBits+2)'(16'hFFFF)) res_wait <= 16'hFFFF;
			else res_wait <= 16'(d_sel);
		end
	end
endmodule

/* design/sqfd_ctrl.sv */
`timescale 1ns / 1ps
module sqfd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	output logic out_valid,
	input  logic out_ready,
	output logic out_last,
	output sqfd_pkg::dp_cmd_t cmd,
	input  sqfd_pkg::dp_sts_t sts
);
	import sqfd_pkg::*;

	typedef enum logic [1:0] {IDLE, DRAIN, SHOW} state_t;
	state_t state_q;
	logic sel_q;
	logic more_q; // result shown is not the last one

	logic in_fire, out_fire;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (state_q == IDLE);
	assign out_last = !more_q;

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		cmd.arrive = in_fire && operation == OP_ARRIVE;
		cmd.reject = cmd.arrive && sts.full_both;
		cmd.tick = in_fire && operation == OP_TICK;
		cmd.pop = (state_q == DRAIN) && sts.head_fires && !out_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			sel_q <= 1'b0;
			more_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_fire) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: begin
					sel_q <= 1'b0;
					if (cmd.reject) begin
						out_valid <= 1'b1;
						more_q <= 1'b0;
						state_q <= SHOW;
					end else if (cmd.tick) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (!out_valid || out_fire) begin
						if (out_valid) begin
							// wait for the freed register before the next result
						end else if (sts.head_fires) begin
							out_valid <= 1'b1;
							more_q <= 1'b1;
						end else if (sel_q == 1'b0) begin
							sel_q <= 1'b1;
						end else begin
							state_q <= IDLE;
						end
					end
				end
				SHOW: begin
					if (out_fire) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

/* design/sqfd_outbuf.sv */
`timescale 1ns / 1ps
// Holds back one drained result so the final one can carry last.
module sqfd_outbuf (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  logic up_more,
	input  logic drain_end,
	input  logic [51:0] up_data,
	output logic dn_valid,
	input  logic dn_ready,
	output logic dn_last,
	output logic [51:0] dn_data
);
	import sqfd_pkg::*;

	logic held_q, hmore_q;
	logic [51:0] hdata_q;
	logic dn_fire;

	// a held "more" result is released when another arrives or drain ends
	assign dn_valid = held_q && (!hmore_q || up_valid || drain_end);
	assign dn_last = !hmore_q || (drain_end && !up_valid);
	assign dn_data = hdata_q;
	assign dn_fire = dn_valid && dn_ready;
	assign up_ready = !held_q || dn_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			hmore_q <= 1'b0;
		end else if (up_valid && up_ready) begin
			held_q <= 1'b1;
			hmore_q <= up_more;
		end else if (dn_fire) begin
			held_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) hdata_q <= up_data;
	end
endmodule

/* bench/dual_queue_sqf_job_dispatcher_core_tb.sv */
`timescale 1ns / 1ps
module dual_queue_sqf_job_dispatcher_core_tb;
	import sqfd_pkg::*;

	typedef struct {
		logic [15:0] job_ref;
		logic [1:0] server;
		logic [1:0] outcome;
		logic [15:0] event_time;
		logic [15:0] wait_res;
		logic last;
	} disp_result_t;

	typedef struct {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] run;
		logic [15:0] dl;
	} queued_job_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic [15:0] job_id;
	logic [15:0] run_length;
	logic [15:0] deadline;
	logic out_valid;
	logic out_ready;
	logic [15:0] job_ref;
	logic [1:0] server;
	logic [1:0] outcome;
	logic [15:0] event_time;
	logic [15:0] wait_res;
	logic last;

	dual_queue_sqf_job_dispatcher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .job_id(job_id),
		.run_length(run_length), .deadline(deadline),
		.out_valid(out_valid), .out_ready(out_ready),
		.job_ref(job_ref), .server(server), .outcome(outcome),
		.event_time(event_time), .wait_res(wait_res), .last(last)
	);

	// predictor state
	logic [15:0] now_m;
	logic [15:0] elapsed_m [2];
	queued_job_t q_m [2][$];
	disp_result_t pending_results [$];

	int errors;
	int cycles;
	int idle_pct;
	bit hold_rx;
	logic [15:0] next_id;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic logic [15:0] clamp16(longint d);
		if (d < 0)
			return 16'd0;
		if (d > 65535)
			return 16'hFFFF;
		return d[15:0];
	endfunction

	function automatic void push_result(logic [15:0] id, logic [1:0] srv, logic [1:0] oc,
			logic [15:0] w);
		disp_result_t r;
		r.job_ref = id;
		r.server = srv;
		r.outcome = oc;
		r.event_time = now_m;
		r.wait_res = w;
		r.last = 1'b0;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void predict_dispatch(logic op, logic [15:0] id, logic [15:0] run,
			logic [15:0] dl);
		queued_job_t j;
		queued_job_t h;
		int s;
		int n0;
		n0 = pending_results.size();
		if (op == OP_ARRIVE) begin
			j.id = id;
			j.run = run;
			j.dl = dl;
			j.arrival = now_m;
			if (q_m[0].size() == 0) begin
				s = 0;
				elapsed_m[0] = 16'd0;
			end else if (q_m[1].size() == 0) begin
				s = 1;
				elapsed_m[1] = 16'd0;
			end else if (q_m[0].size() >= QueueDepth && q_m[1].size() >= QueueDepth) begin
				push_result(id, 2'd0, OC_REJECT, 16'd0);
				pending_results[$].last = 1'b1;
				return;
			end else
				s = (q_m[0].size() <= q_m[1].size()) ? 0 : 1;
			q_m[s].insert(q_m[s].size(), j);
			return;
		end
		if (now_m != 16'hFFFF)
			now_m++;
		for (int k = 0; k < 2; k++)
			if (elapsed_m[k] != 16'hFFFF)
				elapsed_m[k]++;
		for (int k = 0; k < 2; k++) begin
			while (q_m[k].size() > 0) begin
				h = q_m[k][0];
				if (elapsed_m[k] == h.run && now_m <= h.dl)
					push_result(h.id, 2'(k + 1), OC_DONE,
						clamp16(longint'(now_m) - longint'(h.arrival) - longint'(h.run)));
				else if (now_m >= h.dl)
					push_result(h.id, 2'(k + 1), OC_ABORT,
						clamp16(longint'(now_m) - longint'(h.arrival)));
				else
					break;
				void'(q_m[k].pop_front());
				elapsed_m[k] = 16'd0;
			end
		end
		if (pending_results.size() > n0)
			pending_results[$].last = 1'b1;
	endfunction

	task automatic send_item(logic op, logic [15:0] id, logic [15:0] run, logic [15:0] dl);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		job_id <= id;
		run_length <= run;
		deadline <= dl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_dispatch(op, id, run, dl);
	endtask

	// sender side drops valid for random idle gaps and when no item follows
	task automatic send_arrive(logic [15:0] run, logic [15:0] dl);
		send_item(OP_ARRIVE, next_id, run, dl);
		next_id++;
	endtask

	task automatic send_ticks(int n);
		for (int i = 0; i < n; i++)
			send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// receiver
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result id %h", $time, job_ref);
					errors++;
				end else begin
					disp_result_t e;
					e = pending_results.pop_front();
					if (e.job_ref !== job_ref || e.server !== server || e.outcome !== outcome
							|| e.event_time !== event_time || e.wait_res !== wait_res
							|| e.last !== last) begin
						$display("%0t: mismatch exp id %h srv %0d oc %0d t %h w %h l %b",
							$time, e.job_ref, e.server, e.outcome, e.event_time,
							e.wait_res, e.last);
						$display("%0t:          act id %h srv %0d oc %0d t %h w %h l %b",
							$time, job_ref, server, outcome, event_time, wait_res, last);
						errors++;
					end
				end
			end
			out_ready <= !hold_rx && !(idle_pct > 0 && $urandom_range(99, 0) < idle_pct);
		end
	end

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic test_directed();
		send_arrive(16'd1, 16'd100);
		send_arrive(16'd2, 16'd100);
		send_ticks(3);
		// late finish, abort at deadline, zero run length
		send_arrive(16'd3, 16'd5);
		send_arrive(16'd0, 16'd7);
		send_arrive(16'hFFFF, 16'hFFFF);
		send_ticks(4);
		for (int i = 0; i < 9; i++)
			send_arrive(16'd1, 16'd0);
		send_item(OP_ARRIVE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_ARRIVE, 16'h0000, 16'h0001, 16'h0000);
		send_ticks(2);
		wait_drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99, 0) < 45) begin
				if ($urandom_range(9, 0) == 0)
					send_item(OP_ARRIVE, 16'($urandom), 16'($urandom), 16'($urandom));
				else
					send_arrive(16'($urandom_range(6, 0)),
						now_m + 16'($urandom_range(12, 0)));
			end else
				send_ticks(1);
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_rx = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rx = 1'b0;
			end
			begin
				for (int i = 0; i < 10; i++)
					send_arrive(16'd1, now_m + 16'd2);
				send_ticks(6);
			end
		join
		wait_drain();
	endtask

	initial begin
		errors = 0;
		idle_pct = 9;
		hold_rx = 1'b0;
		next_id = 16'd1;
		now_m = 16'd0;
		elapsed_m[0] = 16'd0;
		elapsed_m[1] = 16'd0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TICK;
		job_id = 16'd0;
		run_length = 16'd0;
		deadline = 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_pct = 0;
		test_random(80);
		idle_pct = 9;
		test_random(250);
		test_backpressure();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
